// ===== rtl/core/cmdu_pkg.sv =====
package cmdu_pkg;

    localparam int IN_W              = 16;
    localparam int OUT_W             = 32;
    localparam int DEF_IN_FRAC_BITS  = 12;
    localparam int DEF_OUT_FRAC_BITS = 16;

    localparam int PROD_W = 2 * IN_W;        // one 16x16 product
    localparam int SUM_W  = PROD_W + 1;      // sum or difference of two products
    localparam int DEN_W  = PROD_W;          // b_re^2 + b_im^2 never exceeds 2^31
    localparam int QUO_W  = OUT_W + 1;       // quotient bits kept, one above the result

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = QUO_W;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic       MODE_MUL = 1'b0;
    localparam logic       MODE_DIV = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic                   mode;
        logic signed [IN_W-1:0] a_re;
        logic signed [IN_W-1:0] a_im;
        logic signed [IN_W-1:0] b_re;
        logic signed [IN_W-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] res_re;
        logic signed [OUT_W-1:0] res_im;
        logic [1:0]              status;
    } t_out;

    // state carried through the divider pipeline
    typedef struct packed {
        logic [DEN_W-1:0] rem_re;
        logic [DEN_W-1:0] rem_im;
        logic [QUO_W-1:0] acc_re;
        logic [QUO_W-1:0] acc_im;
        logic [DEN_W-1:0] den;
        logic             neg_re;
        logic             neg_im;
        logic             ovf_re;
        logic             ovf_im;
        logic             den_zero;
        logic             mode;
        logic [OUT_W-1:0] prod_re;
        logic [OUT_W-1:0] prod_im;
        logic             prod_sat;
    } t_div;

endpackage

// ===== rtl/core/cmdu_front.sv =====
module cmdu_front
    import cmdu_pkg::*;
#(
    parameter int IN_FRAC_BITS  = DEF_IN_FRAC_BITS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic [FRONT_STAGES-1:0] i_en,
    input  t_in                     i_data,
    output t_div                    o_div
);

    localparam int NET   = 2 * IN_FRAC_BITS - OUT_FRAC_BITS;
    localparam int SHL   = (NET < 0) ? -NET : 0;
    localparam int SHR   = (NET > 0) ? NET : 0;
    localparam int PW    = SUM_W + SHL;
    localparam int DW    = SUM_W + OUT_FRAC_BITS;

    localparam logic signed [PW-1:0] P_MAX =
        $signed({{(PW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    localparam logic signed [PW-1:0] P_MIN =
        $signed({{(PW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});

    // stage 1: products
    logic signed [PROD_W-1:0] r_rr, r_ii, r_ri, r_ir;
    logic signed [PROD_W-1:0] r_sq_re, r_sq_im;
    logic                     r_mode1;
    logic signed [PROD_W-1:0] n_rr, n_ii, n_ri, n_ir, n_sq_re, n_sq_im;

    always_comb begin
        n_rr    = PROD_W'(i_data.a_re) * PROD_W'(i_data.b_re);
        n_ii    = PROD_W'(i_data.a_im) * PROD_W'(i_data.b_im);
        n_ri    = PROD_W'(i_data.a_re) * PROD_W'(i_data.b_im);
        n_ir    = PROD_W'(i_data.a_im) * PROD_W'(i_data.b_re);
        n_sq_re = PROD_W'(i_data.b_re) * PROD_W'(i_data.b_re);
        n_sq_im = PROD_W'(i_data.b_im) * PROD_W'(i_data.b_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rr    <= n_rr;
            r_ii    <= n_ii;
            r_ri    <= n_ri;
            r_ir    <= n_ir;
            r_sq_re <= n_sq_re;
            r_sq_im <= n_sq_im;
            r_mode1 <= i_data.mode;
        end
    end

    // stage 2: sums for the selected operation and the divisor
    logic [SUM_W-1:0] r_sum_re, r_sum_im;
    logic [DEN_W-1:0] r_den;
    logic             r_mode2;
    logic [SUM_W-1:0] n_sum_re, n_sum_im;
    logic [SUM_W-1:0] w_rr, w_ii, w_ri, w_ir;
    logic [DEN_W-1:0] n_den;

    always_comb begin
        w_rr = {r_rr[PROD_W-1], r_rr};
        w_ii = {r_ii[PROD_W-1], r_ii};
        w_ri = {r_ri[PROD_W-1], r_ri};
        w_ir = {r_ir[PROD_W-1], r_ir};
        if (r_mode1 == MODE_DIV) begin
            n_sum_re = w_rr + w_ii;
            n_sum_im = w_ir - w_ri;
        end else begin
            n_sum_re = w_rr - w_ii;
            n_sum_im = w_ri + w_ir;
        end
        n_den = DEN_W'(r_sq_re) + DEN_W'(r_sq_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sum_re <= n_sum_re;
            r_sum_im <= n_sum_im;
            r_den    <= n_den;
            r_mode2  <= r_mode1;
        end
    end

    // stage 3: product scaling and saturation, divider set-up
    logic signed [PW-1:0] w_sc_re, w_sc_im;
    logic [SUM_W-1:0]     w_mag_re, w_mag_im;
    logic [DW-1:0]        w_dvd_re, w_dvd_im, w_top_re, w_top_im;
    logic                 w_sat_re, w_sat_im;
    t_div                 n_div;
    t_div                 r_div;

    always_comb begin
        w_sc_re = (PW'($signed(r_sum_re)) <<< SHL) >>> SHR;
        w_sc_im = (PW'($signed(r_sum_im)) <<< SHL) >>> SHR;
        w_sat_re = (w_sc_re > P_MAX) || (w_sc_re < P_MIN);
        w_sat_im = (w_sc_im > P_MAX) || (w_sc_im < P_MIN);

        w_mag_re = r_sum_re[SUM_W-1] ? (~r_sum_re + 1'b1) : r_sum_re;
        w_mag_im = r_sum_im[SUM_W-1] ? (~r_sum_im + 1'b1) : r_sum_im;
        w_dvd_re = DW'(w_mag_re) << OUT_FRAC_BITS;
        w_dvd_im = DW'(w_mag_im) << OUT_FRAC_BITS;
        // part of the dividend above the kept quotient bits
        w_top_re = w_dvd_re >> QUO_W;
        w_top_im = w_dvd_im >> QUO_W;

        n_div.rem_re   = w_top_re[DEN_W-1:0];
        n_div.rem_im   = w_top_im[DEN_W-1:0];
        n_div.acc_re   = w_dvd_re[QUO_W-1:0];
        n_div.acc_im   = w_dvd_im[QUO_W-1:0];
        n_div.den      = r_den;
        n_div.neg_re   = r_sum_re[SUM_W-1];
        n_div.neg_im   = r_sum_im[SUM_W-1];
        n_div.ovf_re   = w_top_re >= DW'(r_den);
        n_div.ovf_im   = w_top_im >= DW'(r_den);
        n_div.den_zero = (r_den == '0);
        n_div.mode     = r_mode2;
        if (w_sat_re) begin
            n_div.prod_re = w_sc_re[PW-1] ? P_MIN[OUT_W-1:0] : P_MAX[OUT_W-1:0];
        end else begin
            n_div.prod_re = w_sc_re[OUT_W-1:0];
        end
        if (w_sat_im) begin
            n_div.prod_im = w_sc_im[PW-1] ? P_MIN[OUT_W-1:0] : P_MAX[OUT_W-1:0];
        end else begin
            n_div.prod_im = w_sc_im[OUT_W-1:0];
        end
        n_div.prod_sat = w_sat_re | w_sat_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== rtl/core/cmdu_div_step.sv =====
module cmdu_div_step
    import cmdu_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    // one restoring step per lane: bring in the next dividend bit, subtract if it fits
    logic [DEN_W:0] w_trial_re, w_trial_im, w_den;
    logic           w_ge_re, w_ge_im;
    t_div           n_div;
    t_div           r_div;

    always_comb begin
        w_den      = {1'b0, i_div.den};
        w_trial_re = {i_div.rem_re, i_div.acc_re[QUO_W-1]};
        w_trial_im = {i_div.rem_im, i_div.acc_im[QUO_W-1]};
        w_ge_re    = w_trial_re >= w_den;
        w_ge_im    = w_trial_im >= w_den;

        n_div        = i_div;
        n_div.rem_re = w_ge_re ? DEN_W'(w_trial_re - w_den) : w_trial_re[DEN_W-1:0];
        n_div.rem_im = w_ge_im ? DEN_W'(w_trial_im - w_den) : w_trial_im[DEN_W-1:0];
        n_div.acc_re = {i_div.acc_re[QUO_W-2:0], w_ge_re};
        n_div.acc_im = {i_div.acc_im[QUO_W-2:0], w_ge_im};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== rtl/core/cmdu_back.sv =====
module cmdu_back
    import cmdu_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_div,
    output t_out o_data
);

    localparam logic [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic             w_sat_re, w_sat_im;
    logic [OUT_W-1:0] w_q_re, w_q_im;
    t_out             n_out;
    t_out             r_out;

    always_comb begin
        // negative side may reach one step further than the positive side
        if (i_div.neg_re) begin
            w_sat_re = i_div.ovf_re | i_div.acc_re[QUO_W-1]
                     | (i_div.acc_re[OUT_W-1] & (|i_div.acc_re[OUT_W-2:0]));
            w_q_re   = w_sat_re ? Q_MIN : (~i_div.acc_re[OUT_W-1:0] + 1'b1);
        end else begin
            w_sat_re = i_div.ovf_re | i_div.acc_re[QUO_W-1] | i_div.acc_re[OUT_W-1];
            w_q_re   = w_sat_re ? Q_MAX : i_div.acc_re[OUT_W-1:0];
        end
        if (i_div.neg_im) begin
            w_sat_im = i_div.ovf_im | i_div.acc_im[QUO_W-1]
                     | (i_div.acc_im[OUT_W-1] & (|i_div.acc_im[OUT_W-2:0]));
            w_q_im   = w_sat_im ? Q_MIN : (~i_div.acc_im[OUT_W-1:0] + 1'b1);
        end else begin
            w_sat_im = i_div.ovf_im | i_div.acc_im[QUO_W-1] | i_div.acc_im[OUT_W-1];
            w_q_im   = w_sat_im ? Q_MAX : i_div.acc_im[OUT_W-1:0];
        end

        if (i_div.mode == MODE_MUL) begin
            n_out.res_re = i_div.prod_re;
            n_out.res_im = i_div.prod_im;
            n_out.status = i_div.prod_sat ? ST_SAT : ST_OK;
        end else if (i_div.den_zero) begin
            n_out.res_re = '0;
            n_out.res_im = '0;
            n_out.status = ST_DIV0;
        end else begin
            n_out.res_re = w_q_re;
            n_out.res_im = w_q_im;
            n_out.status = (w_sat_re | w_sat_im) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/core/complex_mul_div_unit_top.sv =====
// complex multiply / divide unit
// input channel: i_valid, o_ready, i_data (mode, a_re, a_im, b_re, b_im in signed Q4.12)
// output channel: o_valid, i_ready, o_data (res_re, res_im in signed Q16.16, status)
// mode 0 gives the product, mode 1 the quotient a/b truncated toward zero; status
// reports saturation or a zero divisor
// pipeline: a result is presented once its beat has passed through three front stages
// (products, sums, scaling and divider set-up), one stage per quotient bit of the
// restoring divider (33 bits), and the output register
// throughput: one beat per cycle while o_ready is high; every stage is a register
// with its own valid bit; when the receiver stalls, valid stages pile up behind the
// output register and empty stages keep taking new beats, so o_ready falls only once
// every stage holds a beat; nothing is dropped or repeated
// reset clears all valid bits; no beat is held afterwards and o_ready is high
module complex_mul_div_unit_top
    import cmdu_pkg::*;
#(
    parameter int IN_FRAC_BITS  = DEF_IN_FRAC_BITS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic [NUM_STAGES-1:0] r_vld, n_vld;
    logic [NUM_STAGES-1:0] w_en, w_shift;
    t_div                  w_div [DIV_STAGES+1];

    // a stage may load when some stage at or after it is free, or the output is taken
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
        assign w_en[k] = i_ready | ~(&r_vld[NUM_STAGES-1:k]);
    end

    assign w_shift = {r_vld[NUM_STAGES-2:0], i_valid};
    assign n_vld   = (w_en & w_shift) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    cmdu_front #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[FRONT_STAGES-1:0]),
        .i_data (i_data),
        .o_div  (w_div[0])
    );

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        cmdu_div_step u_step (
            .i_clk (i_clk),
            .i_en  (w_en[FRONT_STAGES+j]),
            .i_div (w_div[j]),
            .o_div (w_div[j+1])
        );
    end

    cmdu_back u_back (
        .i_clk  (i_clk),
        .i_en   (w_en[NUM_STAGES-1]),
        .i_div  (w_div[DIV_STAGES]),
        .o_data (o_data)
    );

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted beat not captured by the first stage");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> ((&r_vld) && !i_ready))
        else $error("input blocked while the pipeline has room");

    a_div0_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_DIV0) |-> (o_data.res_re == '0 && o_data.res_im == '0))
        else $error("divide by zero with non-zero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == ST_OK || o_data.status == ST_SAT
                     || o_data.status == ST_DIV0))
        else $error("undefined status code");

endmodule
